/* rtl/core/dfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dfs_pkg;
   localparam int MaxVerticesDefault = 64;
   localparam int MaxEdgesDefault = 256;
   localparam int VertexW = 6;
   localparam int CountW = 7;
   localparam logic CmdAddEdge = 1'b0;
   localparam logic CmdSort = 1'b1;

   typedef struct packed {
      logic [0:0] cmd;
      logic [VertexW-1:0] edge_src;
      logic [VertexW-1:0] edge_dst;
   } req_type;

   typedef struct packed {
      logic [VertexW-1:0] vertex;
      logic last;
      logic overflow;
   } rsp_type;
endpackage
`default_nettype wire

/* rtl/core/dfs_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface dfs_req_if;
   logic valid;
   logic ready;
   dfs_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/dfs_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface dfs_rsp_if;
   logic valid;
   logic ready;
   dfs_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/dfs_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// Two-entry command queue between the request port and the walker.
module dfs_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire dfs_pkg::req_type in_data,
   output logic out_valid,
   input wire logic out_ready,
   output dfs_pkg::req_type out_data
);
   import dfs_pkg::*;
   req_type q_ff [2];
   logic rd_ff, wr_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data = q_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= in_data;
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

/* rtl/core/dfs_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// Edge store, depth-first walker and emitter.
module dfs_back #(
   parameter int MAX_VERTICES = dfs_pkg::MaxVerticesDefault,
   parameter int MAX_EDGES = dfs_pkg::MaxEdgesDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic [dfs_pkg::CountW-1:0] vertex_count,
   input wire logic cmd_valid,
   output logic cmd_ready,
   input wire dfs_pkg::req_type cmd_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output dfs_pkg::rsp_type rsp_data
);
   import dfs_pkg::*;
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int PW = EW + 1;
   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int DW = $clog2(MAX_VERTICES + 1);
   localparam logic [PW-1:0] Null = PW'(MAX_EDGES);
   localparam logic [CountW-1:0] MaxV = CountW'(MAX_VERTICES);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_ROOT, S_PUSH, S_TOP, S_POP, S_EDGE, S_EMIT, S_CLEAR
   } state_type;

   logic [VertexW-1:0] tgt_mem [MAX_EDGES];
   logic [PW-1:0] nxt_mem [MAX_EDGES];
   logic [PW-1:0] head_mem [MAX_VERTICES];
   logic [EW-1:0] tail_mem [MAX_VERTICES];
   logic [VW-1:0] stk_v_mem [MAX_VERTICES];
   logic [PW-1:0] stk_p_mem [MAX_VERTICES];
   logic [VW-1:0] fin_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] head_set_ff;
   logic [MAX_VERTICES-1:0] visited_ff;
   logic [PW-1:0] fill_ff;
   logic [DW-1:0] depth_ff, fcnt_ff, emit_ff;
   logic [VW:0] root_ff;
   logic dropped_ff;
   state_type state_ff;
   logic [VW-1:0] cur_v_ff, push_v_ff, stk_v_rd_ff, fin_rd_ff, ld_src_ff;
   logic [PW-1:0] cur_p_ff, stk_p_rd_ff, head_rd_ff, nxt_rd_ff;
   logic [VertexW-1:0] tgt_rd_ff;
   logic [EW-1:0] tail_rd_ff;
   logic ld_bad_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic [CountW-1:0] n_eff;
   logic [VertexW:0] src_x, dst_x;
   logic bad;
   logic [DW-1:0] top_idx, pop_idx, fin_idx, emit_next;
   logic [VW-1:0] src_i;
   logic emit_go, emit_last;

   assign n_eff = (vertex_count == '0) ? CountW'(1) :
                  (vertex_count > MaxV) ? MaxV : vertex_count;
   assign src_x = {1'b0, cmd_data.edge_src};
   assign dst_x = {1'b0, cmd_data.edge_dst};
   assign bad = (fill_ff >= Null) || (CountW'(src_x) >= n_eff)
                || (CountW'(dst_x) >= n_eff);
   assign src_i = cmd_data.edge_src[VW-1:0];
   assign top_idx = depth_ff - DW'(1);
   assign pop_idx = depth_ff - DW'(2);
   assign emit_next = emit_ff + DW'(1);
   assign emit_last = (emit_next == fcnt_ff);
   // first emitted entry is the last finisher; prefetch the next one while emitting
   assign fin_idx = (state_ff == S_EMIT) ? fcnt_ff - emit_ff - DW'(2) : fcnt_ff - DW'(1);
   assign emit_go = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         dropped_ff <= 1'b0;
         visited_ff <= '0;
         head_set_ff <= '0;
         depth_ff <= '0;
         fcnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_go) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  if (cmd_data.cmd == CmdAddEdge) begin
                     // stage the edge and fetch the source's tail for the link
                     ld_src_ff <= src_i;
                     ld_bad_ff <= bad;
                     tail_rd_ff <= tail_mem[src_i];
                     if (!bad) begin
                        tgt_mem[fill_ff[EW-1:0]] <= cmd_data.edge_dst;
                        nxt_mem[fill_ff[EW-1:0]] <= Null;
                     end
                     state_ff <= S_LOAD;
                  end else begin
                     root_ff <= '0;
                     depth_ff <= '0;
                     fcnt_ff <= '0;
                     state_ff <= S_ROOT;
                  end
               end
            end
            S_LOAD: begin
               if (ld_bad_ff) begin
                  dropped_ff <= 1'b1;
               end else begin
                  if (!head_set_ff[ld_src_ff]) begin
                     head_mem[ld_src_ff] <= fill_ff;
                     head_set_ff[ld_src_ff] <= 1'b1;
                  end else begin
                     nxt_mem[tail_rd_ff] <= fill_ff;
                  end
                  tail_mem[ld_src_ff] <= fill_ff[EW-1:0];
                  fill_ff <= fill_ff + PW'(1);
               end
               state_ff <= S_IDLE;
            end
            S_ROOT: begin
               if (CountW'(root_ff) >= n_eff) begin
                  fin_rd_ff <= fin_mem[fin_idx[VW-1:0]];
                  emit_ff <= '0;
                  state_ff <= (fcnt_ff == '0) ? S_CLEAR : S_EMIT;
               end else begin
                  if (!visited_ff[root_ff[VW-1:0]]) begin
                     visited_ff[root_ff[VW-1:0]] <= 1'b1;
                     push_v_ff <= root_ff[VW-1:0];
                     head_rd_ff <= head_mem[root_ff[VW-1:0]];
                     state_ff <= S_PUSH;
                  end
                  root_ff <= root_ff + (VW+1)'(1);
               end
            end
            S_PUSH: begin
               // spill the current top below the new entry
               if (depth_ff != '0) begin
                  stk_v_mem[top_idx[VW-1:0]] <= cur_v_ff;
                  stk_p_mem[top_idx[VW-1:0]] <= cur_p_ff;
               end
               cur_v_ff <= push_v_ff;
               cur_p_ff <= head_set_ff[push_v_ff] ? head_rd_ff : Null;
               depth_ff <= depth_ff + DW'(1);
               state_ff <= S_TOP;
            end
            S_TOP: begin
               if (cur_p_ff >= Null) begin
                  if (fcnt_ff < DW'(MAX_VERTICES)) begin
                     fin_mem[fcnt_ff[VW-1:0]] <= cur_v_ff;
                     fcnt_ff <= fcnt_ff + DW'(1);
                  end
                  depth_ff <= top_idx;
                  stk_v_rd_ff <= stk_v_mem[pop_idx[VW-1:0]];
                  stk_p_rd_ff <= stk_p_mem[pop_idx[VW-1:0]];
                  state_ff <= (top_idx == '0) ? S_ROOT : S_POP;
               end else begin
                  tgt_rd_ff <= tgt_mem[cur_p_ff[EW-1:0]];
                  nxt_rd_ff <= nxt_mem[cur_p_ff[EW-1:0]];
                  state_ff <= S_EDGE;
               end
            end
            S_POP: begin
               cur_v_ff <= stk_v_rd_ff;
               cur_p_ff <= stk_p_rd_ff;
               state_ff <= S_TOP;
            end
            S_EDGE: begin
               cur_p_ff <= nxt_rd_ff;
               if (CountW'({1'b0, tgt_rd_ff}) < n_eff
                   && !visited_ff[tgt_rd_ff[VW-1:0]]
                   && depth_ff < DW'(MAX_VERTICES)) begin
                  visited_ff[tgt_rd_ff[VW-1:0]] <= 1'b1;
                  push_v_ff <= tgt_rd_ff[VW-1:0];
                  head_rd_ff <= head_mem[tgt_rd_ff[VW-1:0]];
                  state_ff <= S_PUSH;
               end else begin
                  state_ff <= S_TOP;
               end
            end
            S_EMIT: begin
               if (emit_go) begin
                  rsp_ff.vertex <= VertexW'(fin_rd_ff);
                  rsp_ff.last <= emit_last;
                  rsp_ff.overflow <= dropped_ff;
                  fin_rd_ff <= fin_mem[fin_idx[VW-1:0]];
                  emit_ff <= emit_next;
                  if (emit_last) state_ff <= S_CLEAR;
               end
            end
            S_CLEAR: begin
               head_set_ff <= '0;
               visited_ff <= '0;
               fill_ff <= '0;
               dropped_ff <= 1'b0;
               depth_ff <= '0;
               fcnt_ff <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/core/dfs_topological_sort.sv */
`timescale 1ns / 1ps
`default_nettype none
// Depth-first topological sort. Each cmd=0 transfer appends one directed edge
// to its source's neighbor list; the walker stores it by a tail fetch, then a
// link. A cmd=1 transfer walks the graph from unvisited roots in index order,
// neighbors in insertion order, and returns the reverse finishing order as one
// rsp transfer per vertex, with last on the final vertex and overflow set if
// any edge was dropped. A sort scans each root index, pushes, finishes and
// pops each vertex and scans each edge of a visited vertex, then emits one
// vertex per cycle while rsp is ready, and finally clears the graph. Edges
// beyond MAX_EDGES or with an endpoint at or above the effective vertex count
// (vertex_count clamped to 1..MAX_VERTICES) are dropped. A two-entry queue
// decouples request intake from the walker and registers each request on its
// way. Write vertex_count only while no transfer is in flight.
module dfs_topological_sort #(
   parameter int MAX_VERTICES = dfs_pkg::MaxVerticesDefault,
   parameter int MAX_EDGES = dfs_pkg::MaxEdgesDefault
) (
   input wire logic clock,
   input wire logic reset,
   dfs_req_if.sink req,
   dfs_rsp_if.source rsp,
   input wire logic csr_write_enable,
   input wire logic [dfs_pkg::CountW-1:0] csr_write_data
);
   import dfs_pkg::*;
   logic [CountW-1:0] vcount_ff;
   logic q_valid, q_ready;
   req_type q_data;

   // hold vertex count; reset to 64, the default MAX_VERTICES
   always_ff @(posedge clock) begin
      if (reset) vcount_ff <= CountW'(64);
      else if (csr_write_enable) vcount_ff <= csr_write_data;
   end

   dfs_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.payload),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   dfs_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_back (
      .clock, .reset, .vertex_count(vcount_ff),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.payload)
   );
endmodule
`default_nettype wire

/* rtl/core/dfs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module dfs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire dfs_pkg::rsp_type rsp_payload
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp changed while stalled");
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last ##1 rsp_valid
      |-> rsp_payload.overflow == $past(rsp_payload.overflow))
      else $error("overflow changed within one order");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");
endmodule
bind dfs_topological_sort dfs_checker u_chk (
   .clock, .reset, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload)
);
`default_nettype wire
